/* rtl/core/utf8_text_glyph_layout_defines.svh */
// Assertion macros shared by the glyph layout RTL.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef UTF8_TEXT_GLYPH_LAYOUT_DEFINES_SVH
`define UTF8_TEXT_GLYPH_LAYOUT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define UTGL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utgl: assertion failed");

// Check cons in the cycle after ante.
`define UTGL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utgl: assertion failed");

`endif

/* rtl/core/utgl_pkg.sv */
// Types, codes and helper functions of the UTF-8 glyph layout block.
// No dependencies; imported by utgl_front, utgl_back and the top module.
package utgl_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TEXT  = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    TAIL_NONE    = 2'd0,
    TAIL_GLYPH   = 2'd1,
    TAIL_NEWLINE = 2'd2
  } tail_t;

  localparam logic [1:0] TBL_CTRL  = 2'd0;
  localparam logic [1:0] TBL_BASIC = 2'd1;
  localparam logic [1:0] TBL_EXT   = 2'd2;

  localparam logic [6:0] GLYPH_QMARK  = 7'd63;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_NUL     = 8'h00;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] tbl;
    logic [6:0] index;
  } glyph_t;

  localparam glyph_t QMARK_GLYPH = '{tbl: TBL_BASIC, index: GLYPH_QMARK};

  typedef struct packed {
    logic       is_start;
    logic [1:0] n_qmark;
    tail_t      tail;
    glyph_t     glyph;
  } cmd_ctl_t;

  function automatic logic is_cont(logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  function automatic logic is_lead2(logic [7:0] b);
    return (b & 8'hE0) == 8'hC0;
  endfunction

  function automatic logic is_lead3(logic [7:0] b);
    return (b & 8'hF0) == 8'hE0;
  endfunction

  function automatic glyph_t classify(logic [15:0] cp);
    glyph_t     g;
    logic [7:0] off;
    off = cp[7:0] - 8'hA0;
    if (cp < 16'h0020) begin
      g.tbl   = TBL_CTRL;
      g.index = cp[6:0];
    end else if (cp < 16'h0080) begin
      g.tbl   = TBL_BASIC;
      g.index = cp[6:0];
    end else if (cp >= 16'h00A0 && cp <= 16'h00FF) begin
      g.tbl   = TBL_EXT;
      g.index = off[6:0];
    end else begin
      g = QMARK_GLYPH;
    end
    return g;
  endfunction

endpackage

/* rtl/core/utgl_if.sv */
// Channel interfaces of the UTF-8 glyph layout block: input, result, config.
// No dependencies.
interface utgl_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic [7:0]                   text_byte;
  modport source (output valid, action, origin_x, origin_y, text_byte, input ready);
  modport sink   (input valid, action, origin_x, origin_y, text_byte, output ready);
endinterface

interface utgl_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   glyph_table;
  logic [6:0]                   glyph_index;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_of_run;
  modport source (output valid, glyph_table, glyph_index, pixel_x, pixel_y, last_of_run,
                  input ready);
  modport sink   (input valid, glyph_table, glyph_index, pixel_x, pixel_y, last_of_run,
                  output ready);
endinterface

interface utgl_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] scale_factor;
  modport source (output valid, scale_factor, input ready);
  modport sink   (input valid, scale_factor, output ready);
endinterface

/* rtl/core/utgl_front.sv */
// Front end: accepts requests, assembles UTF-8 sequences, emits layout commands.
// Depends on utgl_pkg and utgl_in_if.
module utgl_front (
  input  logic              clk,
  input  logic              rst_n,
  utgl_in_if.sink           in_chan,
  input  logic              scale_zero,
  input  logic              q_full,
  output logic              push,
  output utgl_pkg::cmd_ctl_t cmd_ctl
);
  import utgl_pkg::*;

  logic [1:0] held_count_r, held_count_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic       accept;
  logic       alone;
  logic [7:0] b;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.text_byte;

  always_comb begin
    cmd_ctl          = '0;
    cmd_ctl.tail     = TAIL_NONE;
    held_count_nxt   = held_count_r;
    held0_nxt        = held0_r;
    held1_nxt        = held1_r;
    alone            = 1'b0;
    if (accept) begin
      case (in_chan.action)
        ACT_START: begin
          cmd_ctl.is_start = 1'b1;
          held_count_nxt   = 2'd0;
        end
        ACT_TEXT, ACT_END: begin
          if (!scale_zero) begin
            if (in_chan.action == ACT_END || b == BYTE_NUL) begin
              cmd_ctl.n_qmark = held_count_r;
              held_count_nxt  = 2'd0;
            end else begin
              case (held_count_r)
                2'd0: alone = 1'b1;
                2'd1: begin
                  if (!is_cont(b)) begin
                    cmd_ctl.n_qmark = 2'd1;
                    alone           = 1'b1;
                  end else if (is_lead2(held0_r)) begin
                    cmd_ctl.tail   = TAIL_GLYPH;
                    cmd_ctl.glyph  = classify({5'd0, held0_r[4:0], b[5:0]});
                    held_count_nxt = 2'd0;
                  end else begin
                    held1_nxt      = b;
                    held_count_nxt = 2'd2;
                  end
                end
                2'd2: begin
                  if (is_cont(b)) begin
                    cmd_ctl.tail   = TAIL_GLYPH;
                    cmd_ctl.glyph  = classify({held0_r[3:0], held1_r[5:0], b[5:0]});
                    held_count_nxt = 2'd0;
                  end else begin
                    cmd_ctl.n_qmark = 2'd2;
                    alone           = 1'b1;
                  end
                end
                default: alone = 1'b1;
              endcase
              if (alone) begin
                held_count_nxt = 2'd0;
                if (b == BYTE_NEWLINE) begin
                  cmd_ctl.tail = TAIL_NEWLINE;
                end else if (b < 8'h80) begin
                  cmd_ctl.tail  = TAIL_GLYPH;
                  cmd_ctl.glyph = classify({8'd0, b});
                end else if (is_lead2(b) || is_lead3(b)) begin
                  held0_nxt      = b;
                  held_count_nxt = 2'd1;
                end else begin
                  cmd_ctl.tail  = TAIL_GLYPH;
                  cmd_ctl.glyph = QMARK_GLYPH;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push = accept &&
                (cmd_ctl.is_start || cmd_ctl.n_qmark != 2'd0 || cmd_ctl.tail != TAIL_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
    end else begin
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

endmodule

/* rtl/core/utgl_queue.sv */
// Short command queue between the front and back ends of the glyph layout.
// Depends on the assertion macro header.
module utgl_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  `include "utf8_text_glyph_layout_defines.svh"

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  assign full  = count_r == FULL_CNT;
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `UTGL_ASSERT_NOW(a_no_push_full, clk, rst_n, full, !push)
  `UTGL_ASSERT_NOW(a_no_pop_empty, clk, rst_n, empty, !pop)
  `UTGL_ASSERT_NXT(a_count_step, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

/* rtl/core/utgl_back.sv */
// Back end: runs layout commands, tracks the cursor and drives the result register.
// Depends on utgl_pkg, utgl_out_if and the assertion macro header.
module utgl_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  utgl_pkg::cmd_ctl_t           head,
  input  logic signed [COORD_BITS-1:0] head_ox,
  input  logic signed [COORD_BITS-1:0] head_oy,
  input  logic [4:0]                   scale_factor,
  output logic                         pop,
  utgl_out_if.source                   out_chan
);
  import utgl_pkg::*;
  `include "utf8_text_glyph_layout_defines.svh"

  localparam int SW = COORD_BITS + 9;
  localparam logic signed [SW-1:0] MAX_S =
    {{(SW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};

  function automatic logic signed [COORD_BITS-1:0] sat_add(
    logic signed [COORD_BITS-1:0] x,
    logic [7:0]                   step
  );
    logic signed [SW-1:0] s;
    s = SW'(x) + signed'({{(SW - 8){1'b0}}, step});
    return (s > MAX_S) ? MAX_S[COORD_BITS-1:0] : s[COORD_BITS-1:0];
  endfunction

  logic signed [COORD_BITS-1:0] col_r, col_nxt;
  logic signed [COORD_BITS-1:0] row_r, row_nxt;
  logic signed [COORD_BITS-1:0] line_r, line_nxt;
  logic [1:0]                   q_done_r, q_done_nxt;
  logic                         out_valid_r;
  logic [1:0]                   out_table_r;
  logic [6:0]                   out_index_r;
  logic signed [COORD_BITS-1:0] out_px_r;
  logic signed [COORD_BITS-1:0] out_py_r;
  logic                         out_last_r;
  logic                         can_go;
  logic [1:0]                   remaining;
  logic [7:0]                   step;
  logic                         emit;
  logic                         emit_qm;
  logic                         emit_last;
  glyph_t                       emit_glyph;

  assign can_go    = !out_valid_r || out_chan.ready;
  assign remaining = head.n_qmark - q_done_r;
  assign step      = {scale_factor, 3'b000};

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    line_nxt   = line_r;
    q_done_nxt = q_done_r;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_qm    = 1'b0;
    emit_last  = 1'b0;
    emit_glyph = QMARK_GLYPH;
    if (!q_empty && can_go) begin
      if (head.is_start) begin
        col_nxt    = head_ox;
        line_nxt   = head_ox;
        row_nxt    = head_oy;
        pop        = 1'b1;
        q_done_nxt = 2'd0;
      end else if (remaining != 2'd0) begin
        emit    = 1'b1;
        emit_qm = 1'b1;
        col_nxt = sat_add(col_r, step);
        if (remaining == 2'd1 && head.tail != TAIL_GLYPH) begin
          emit_last  = 1'b1;
          pop        = 1'b1;
          q_done_nxt = 2'd0;
          if (head.tail == TAIL_NEWLINE) begin
            col_nxt = line_r;
            row_nxt = sat_add(row_r, step);
          end
        end else begin
          q_done_nxt = q_done_r + 2'd1;
        end
      end else begin
        pop        = 1'b1;
        q_done_nxt = 2'd0;
        case (head.tail)
          TAIL_GLYPH: begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_glyph = head.glyph;
            col_nxt    = sat_add(col_r, step);
          end
          TAIL_NEWLINE: begin
            col_nxt = line_r;
            row_nxt = sat_add(row_r, step);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      line_r      <= '0;
      q_done_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      line_r   <= line_nxt;
      q_done_r <= q_done_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_table_r <= emit_glyph.tbl;
      out_index_r <= emit_glyph.index;
      out_px_r    <= col_r;
      out_py_r    <= row_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.glyph_table = out_table_r;
  assign out_chan.glyph_index = out_index_r;
  assign out_chan.pixel_x     = out_px_r;
  assign out_chan.pixel_y     = out_py_r;
  assign out_chan.last_of_run = out_last_r;

  `UTGL_ASSERT_NOW(a_qdone_range, clk, rst_n, !q_empty, q_done_r <= head.n_qmark)
  `UTGL_ASSERT_NXT(a_glyph_last, clk, rst_n, pop && !head.is_start && head.tail == TAIL_GLYPH, out_valid_r && out_last_r)
  `UTGL_ASSERT_NXT(a_qmark_out, clk, rst_n, emit_qm, out_index_r == GLYPH_QMARK && out_table_r == TBL_BASIC)

endmodule

/* rtl/core/utf8_text_glyph_layout.sv */
// UTF-8 glyph layout: one text byte per cycle goes in while the queue has room; each
// decoded character comes out as a glyph table, an index and the pixel position of its
// cell, 8 pixels times the scale factor on a side. The front end takes one request per
// cycle while the queue has room and turns it into at most one command; a four-entry
// queue feeds the back end, which delivers one result or one cursor move per cycle
// while the result channel is not stalled. An item that completes or starts nothing
// pushes no command; a broken sequence gives up to three '?' results. A result passes
// through the queue and then the result register. Both sides stall through the queue.
// Depends on utgl_pkg, utgl_if, utgl_front, utgl_queue and utgl_back.
module utf8_text_glyph_layout #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  utgl_cfg_if.sink    cfg_chan,
  utgl_in_if.sink     in_chan,
  utgl_out_if.source  out_chan
);
  import utgl_pkg::*;

  localparam int CTL_BITS = $bits(cmd_ctl_t);
  localparam int QW       = CTL_BITS + 2 * COORD_BITS;

  logic [4:0]                   scale_factor_r;
  logic                         q_full;
  logic                         q_empty;
  logic                         push;
  logic                         pop;
  cmd_ctl_t                     cmd_ctl;
  cmd_ctl_t                     head;
  logic [QW-1:0]                q_rdata;
  logic signed [COORD_BITS-1:0] head_ox;
  logic signed [COORD_BITS-1:0] head_oy;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r <= 5'd1;
    end else if (cfg_chan.valid) begin
      scale_factor_r <= cfg_chan.scale_factor;
    end
  end

  utgl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .scale_zero (scale_factor_r == 5'd0),
    .q_full     (q_full),
    .push       (push),
    .cmd_ctl    (cmd_ctl)
  );

  utgl_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({cmd_ctl, in_chan.origin_x, in_chan.origin_y}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign head    = cmd_ctl_t'(q_rdata[QW-1 -: CTL_BITS]);
  assign head_ox = q_rdata[2*COORD_BITS-1 -: COORD_BITS];
  assign head_oy = q_rdata[COORD_BITS-1:0];

  utgl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .head         (head),
    .head_ox      (head_ox),
    .head_oy      (head_oy),
    .scale_factor (scale_factor_r),
    .pop          (pop),
    .out_chan     (out_chan)
  );

endmodule
